// File: design/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared codes and keyword tables for the interval string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

    localparam int NUM_KEYS = 14;
    localparam int KEY_SLOTS = 16;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_base;
    typedef logic [1:0] t_status;
    typedef logic [3:0] t_pos;

    localparam t_base BASE_MINUTE    = 3'd0;
    localparam t_base BASE_HOUR      = 3'd1;
    localparam t_base BASE_DAY       = 3'd2;
    localparam t_base BASE_WEEK      = 3'd3;
    localparam t_base BASE_MONTH     = 3'd4;
    localparam t_base BASE_YEAR      = 3'd5;
    localparam t_base BASE_IRREGULAR = 3'd6;

    localparam t_status ST_ALL_DIGITS = 2'd0;
    localparam t_status ST_KEYWORD    = 2'd1;
    localparam t_status ST_UNKNOWN    = 2'd2;

    localparam logic [3:0] KEY_NONE = 4'd0;

    localparam logic [NUM_KEYS-1:0] ALL_KEYS = '1;

    // keyword text, padded with zeros to sixteen slots
    localparam t_char KEY_TEXT [NUM_KEYS][KEY_SLOTS] = '{
        '{"m", "i", "n", "u", "t", "e", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"m", "i", "n", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"h", "o", "u", "r", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"h", "r", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"d", "a", "y", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"w", "e", "e", "k", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"w", "k", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"m", "o", "n", "t", "h", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"m", "o", "n", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"y", "e", "a", "r", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"y", "r", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"i", "r", "r", "e", "g", "u", "l", "a", "r", 0, 0, 0, 0, 0, 0, 0},
        '{"i", "r", "r", "e", "g", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{"i", "r", "r", 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    localparam t_pos KEY_LEN [NUM_KEYS] = '{
        4'd6, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd2,
        4'd5, 4'd3, 4'd4, 4'd2, 4'd9, 4'd5, 4'd3
    };

    localparam t_base KEY_BASE [NUM_KEYS] = '{
        BASE_MINUTE, BASE_MINUTE, BASE_HOUR, BASE_HOUR, BASE_DAY,
        BASE_WEEK, BASE_WEEK, BASE_MONTH, BASE_MONTH, BASE_YEAR,
        BASE_YEAR, BASE_IRREGULAR, BASE_IRREGULAR, BASE_IRREGULAR
    };

endpackage

`default_nettype wire

// File: design/interval_string_parser.sv
// ----------------------------------------------------------------------------
// interval_string_parser
// Character-stream parser for interval strings such as "12min".
//
// Input channel: one beat per character. tdata[7:0] is the character,
// tuser marks a beat that carries a character (low for an empty end beat),
// tlast marks the final beat of the string.
// Output channel: one beat per string, issued for the tlast input beat.
// Leading decimal digits form a saturating multiplier; the rest is matched,
// case folded, against fourteen unit keywords as prefixes, first one wins.
// The accepted tlast beat is held in the input register; its result is then
// registered in the output register. Throughput: one character per cycle
// while no tlast beat waits in the input register on a stalled receiver.
// Reset clears the running state and both valid bits. When the receiver
// stalls, the result holds in the output register; characters keep flowing
// until a second tlast beat reaches the input register, which then holds.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_string_parser
    import isp_pkg::*;
#(
    parameter int MULT_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire        i_s_axis_tuser,   // [0] has_char
    input  wire        i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [2:0] base_unit, [18:3] multiplier,
                                         // [22:19] keyword, [26:23] keyword_length,
                                         // [28:27] status, [29] overflow
);

    localparam int PROD_W = MULT_BITS + 4;
    localparam logic [MULT_BITS-1:0] MULT_MAX = '1;

    logic                 r_in_valid;
    t_char                r_in_ch;
    logic                 r_in_has;
    logic                 r_in_last;

    logic [MULT_BITS-1:0] r_acc, n_acc;
    logic                 r_seen, n_seen;
    logic                 r_in_let, n_in_let;
    logic [NUM_KEYS-1:0]  r_alive, n_alive;
    t_pos                 r_lpos, n_lpos;
    logic                 r_sat, n_sat;

    logic                 r_out_valid;
    t_base                r_out_base, n_out_base;
    logic [15:0]          r_out_mult, n_out_mult;
    logic [3:0]           r_out_key, n_out_key;
    t_pos                 r_out_klen, n_out_klen;
    t_status              r_out_status, n_out_status;
    logic                 r_out_ovf, n_out_ovf;

    logic                 w_proc;
    t_char                w_lc;
    logic                 w_digit;
    logic [PROD_W-1:0]    w_prod;

    assign w_proc = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_has  <= i_s_axis_tuser;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // character update
    always_comb begin
        w_lc    = (r_in_ch inside {[8'h41:8'h5A]}) ? r_in_ch + 8'd32 : r_in_ch;
        w_digit = !r_in_let && (r_in_ch inside {[8'h30:8'h39]});
        w_prod  = (PROD_W'(r_acc) << 3) + (PROD_W'(r_acc) << 1)
                + PROD_W'(r_in_ch - 8'h30);
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_in_let = r_in_let;
        n_alive  = r_alive;
        n_lpos   = r_lpos;
        n_sat    = r_sat;
        if (r_in_has) begin
            if (w_digit) begin
                n_seen = 1'b1;
                if (w_prod > PROD_W'(MULT_MAX)) begin
                    n_acc = MULT_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_acc = w_prod[MULT_BITS-1:0];
                end
            end else begin
                n_in_let = 1'b1;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (r_lpos < KEY_LEN[k] && KEY_TEXT[k][r_lpos] != w_lc) begin
                        n_alive[k] = 1'b0;
                    end
                end
                if (r_lpos != 4'd15) begin
                    n_lpos = r_lpos + 4'd1;
                end
            end
        end
    end

    // result for the string
    always_comb begin
        n_out_base   = BASE_HOUR;
        n_out_key    = KEY_NONE;
        n_out_klen   = 4'd0;
        n_out_mult   = 16'(n_acc);
        n_out_ovf    = n_sat;
        n_out_status = ST_ALL_DIGITS;
        if (!(n_seen && !n_in_let)) begin
            n_out_mult   = n_seen ? 16'(n_acc) : 16'd1;
            n_out_ovf    = n_seen && n_sat;
            n_out_status = ST_UNKNOWN;
            for (int k = NUM_KEYS - 1; k >= 0; k--) begin
                if (n_alive[k] && n_lpos >= KEY_LEN[k]) begin
                    n_out_base   = KEY_BASE[k];
                    n_out_key    = 4'(k + 1);
                    n_out_klen   = KEY_LEN[k];
                    n_out_status = ST_KEYWORD;
                end
            end
        end
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_seen   <= 1'b0;
            r_in_let <= 1'b0;
            r_alive  <= ALL_KEYS;
            r_lpos   <= 4'd0;
            r_sat    <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_acc    <= '0;
                r_seen   <= 1'b0;
                r_in_let <= 1'b0;
                r_alive  <= ALL_KEYS;
                r_lpos   <= 4'd0;
                r_sat    <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_seen   <= n_seen;
                r_in_let <= n_in_let;
                r_alive  <= n_alive;
                r_lpos   <= n_lpos;
                r_sat    <= n_sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && r_in_last) begin
            r_out_base   <= n_out_base;
            r_out_mult   <= n_out_mult;
            r_out_key    <= n_out_key;
            r_out_klen   <= n_out_klen;
            r_out_status <= n_out_status;
            r_out_ovf    <= n_out_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_ovf, r_out_status, r_out_klen,
                              r_out_key, r_out_mult, r_out_base};

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc && r_in_last))
        else $error("result beat without a final character");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_alive == ALL_KEYS && r_lpos == 4'd0 && !r_seen))
        else $error("state not cleared after final character");

    a_status_keyword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_status == ST_KEYWORD) == (r_out_key != KEY_NONE)
                         && (r_out_key == KEY_NONE) == (r_out_klen == 4'd0)))
        else $error("status and keyword disagree");

endmodule

`default_nettype wire
